### rtl/core/cif_pkg.sv
// ----------------------------------------------------------------------------
// Complex IIR filter package
// Shared widths, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package cif_pkg;

    localparam int SAMPLE_W = 16;   // Q1.15 sample component
    localparam int COEF_W   = 32;   // Q4.28 coefficient component
    localparam int CFG_W    = 64;   // packed complex coefficient
    localparam int STATE_W  = 40;   // Q16.24 delay component
    localparam int ROUND_SH = 19;   // Q5.43 product sum to Q16.24
    localparam int OUT_SH   = 9;    // Q16.24 to Q1.15

    localparam logic [COEF_W-1:0] ONE_Q4_28 = 32'h1000_0000;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_B0 = 3'd0;
    localparam t_cfg_idx CFG_B1 = 3'd1;
    localparam t_cfg_idx CFG_B2 = 3'd2;
    localparam t_cfg_idx CFG_A1 = 3'd3;
    localparam t_cfg_idx CFG_A2 = 3'd4;
    localparam t_cfg_idx CFG_A3 = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

endpackage

### rtl/core/complex_iir_filter.sv
// o_stall is high while a sample is in work, so a new request is taken only after the
// last one is through. The single shared 16x32 multiplier does all the work: four real
// products per complex product, 2*ORDER complex products per sample, plus two pipeline
// drains.
// Reset (synchronous, active low) clears the sequencer, the delay line and the output
// valid flag, and loads b0 = 1.0 with all other coefficients zero.
// ----------------------------------------------------------------------------
// Complex IIR filter
// Transposed direct form II complex IIR filter, fixed point, built around one
// shared real multiplier under a small sequencer.
// ----------------------------------------------------------------------------
module complex_iir_filter #(
    parameter int ORDER = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [cif_pkg::SAMPLE_W-1:0]   i_sample_re,
    input  logic signed [cif_pkg::SAMPLE_W-1:0]   i_sample_im,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [cif_pkg::SAMPLE_W-1:0]   o_out_re,
    output logic signed [cif_pkg::SAMPLE_W-1:0]   o_out_im,
    output logic                                  o_clipped,
    input  logic                                  i_cfg_we,
    input  cif_pkg::t_cfg_idx                     i_cfg_idx,
    input  logic [cif_pkg::CFG_W-1:0]             i_cfg_data
);
    import cif_pkg::*;

    localparam int ORD = (ORDER < 1) ? 1 : ((ORDER > 3) ? 3 : ORDER);
    localparam int JW  = $clog2(2 * ORD);
    localparam logic [JW-1:0] LAST_JOB = JW'(2 * ORD - 1);
    localparam int PW  = SAMPLE_W + COEF_W;          // one real product
    localparam int AW  = PW + 1;                     // sum of two products
    localparam int VW  = AW + 1 - ROUND_SH;          // rounded part, Q16.24
    localparam int UW  = STATE_W + 2;                // delay update headroom
    localparam int RW  = UW + 1 - OUT_SH;            // rounded output before clamp
    localparam logic signed [AW:0] ROUND_HALF = (AW + 1)'(1) <<< (ROUND_SH - 1);
    localparam logic signed [UW:0] OUT_HALF   = (UW + 1)'(1) <<< (OUT_SH - 1);
    localparam logic signed [UW-1:0] ST_MAX =
        {{(UW - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
    localparam logic signed [UW-1:0] ST_MIN =
        {{(UW - STATE_W + 1){1'b1}}, {(STATE_W - 1){1'b0}}};
    localparam logic signed [RW-1:0] Y_MAX = RW'(32767);
    localparam logic signed [RW-1:0] Y_MIN = -RW'(32768);

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [UW-1:0] v);
        logic signed [UW-1:0] c;
        c = v;
        if (v > ST_MAX) begin
            c = ST_MAX;
        end else if (v < ST_MIN) begin
            c = ST_MIN;
        end
        return c[STATE_W-1:0];
    endfunction

    // Returns {clip, value}: round half up to Q1.15, then clamp.
    function automatic logic [SAMPLE_W:0] round_out(input logic signed [UW-1:0] v);
        logic signed [UW:0]   t;
        logic signed [RW-1:0] r;
        logic [SAMPLE_W:0]    res;
        t = {v[UW-1], v} + OUT_HALF;
        r = t[UW:OUT_SH];
        if (r > Y_MAX) begin
            res = {1'b1, Y_MAX[SAMPLE_W-1:0]};
        end else if (r < Y_MIN) begin
            res = {1'b1, Y_MIN[SAMPLE_W-1:0]};
        end else begin
            res = {1'b0, r[SAMPLE_W-1:0]};
        end
        return res;
    endfunction

    // Sequencer
    t_state               r_state, n_state;
    logic [JW-1:0]        r_job, n_job;
    logic [1:0]           r_ph, n_ph;

    // Configuration
    logic [CFG_W-1:0]     r_coef_b [0:2];
    logic [CFG_W-1:0]     r_coef_a [0:2];

    // Working values
    logic signed [SAMPLE_W-1:0] r_x_re, r_x_im, r_y_re, r_y_im;
    logic                       r_clip;
    logic signed [STATE_W-1:0]  r_dly_re [0:ORD-1];
    logic signed [STATE_W-1:0]  r_dly_im [0:ORD-1];

    // Multiplier stage and its tag
    logic signed [PW-1:0] r_prod;
    logic                 r_tg_vld;
    logic [JW-1:0]        r_tg_job;
    logic [1:0]           r_tg_ph;

    // Accumulate stage
    logic signed [AW-1:0] r_acc;
    logic signed [UW-1:0] r_upd_re, r_upd_im;

    // Output register
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_re, r_out_im;
    logic                       r_out_clip;

    // Control decodes
    logic issue, drain_done, out_free, y_load, out_load;

    // Issue side
    logic [JW:0]                tap_w;
    logic [1:0]                 tap;
    logic                       use_x;
    logic [CFG_W-1:0]           coef;
    logic signed [COEF_W-1:0]   coef_re, coef_im;
    logic signed [SAMPLE_W-1:0] op_s;
    logic signed [COEF_W-1:0]   op_c;
    logic signed [PW-1:0]       mul_w;

    // Accumulate side
    logic [JW:0]                tg_tap_w;
    logic [1:0]                 tg_tap, wr_idx;
    logic                       tg_first, tg_bterm, tg_aterm, tg_final;
    logic signed [AW-1:0]       prod_ext, sum;
    logic signed [AW:0]         rnd;
    logic signed [VW-1:0]       part_v;
    logic signed [UW-1:0]       v_ext, base_ext, upd_val, wr_pre;
    logic signed [STATE_W-1:0]  dly_rd, wr_val;
    logic                       wr_re, wr_im;
    logic [SAMPLE_W:0]          y_re_c, y_im_c;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_ph    = r_ph;
        case (r_state)
            S_IDLE: begin
                n_job = '0;
                n_ph  = '0;
                if (i_valid) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    if (r_job == '0 || r_job == LAST_JOB) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_job = r_job + JW'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (drain_done) begin
                    if (r_job == '0) begin
                        n_state = S_ISSUE;
                        n_job   = JW'(1);
                        n_ph    = '0;
                    end else if (out_free) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_stall    = 1'b1;
        issue      = 1'b0;
        drain_done = !r_tg_vld;
        out_free   = !r_out_vld || !i_stall;
        y_load     = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_ISSUE: begin
                issue = 1'b1;
            end
            S_DRAIN: begin
                y_load   = drain_done && (r_job == '0);
                out_load = drain_done && (r_job != '0) && out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_ph    <= n_ph;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b[0] <= {ONE_Q4_28, {COEF_W{1'b0}}};
            r_coef_b[1] <= '0;
            r_coef_b[2] <= '0;
            r_coef_a[0] <= '0;
            r_coef_a[1] <= '0;
            r_coef_a[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_B0:  r_coef_b[0] <= i_cfg_data;
                CFG_B1:  r_coef_b[1] <= i_cfg_data;
                CFG_B2:  r_coef_b[2] <= i_cfg_data;
                CFG_A1:  r_coef_a[0] <= i_cfg_data;
                CFG_A2:  r_coef_a[1] <= i_cfg_data;
                CFG_A3:  r_coef_a[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Issue: job 0 is b0*x, odd jobs are b*x terms, other even jobs and the last
    // job are feedback a*y terms. Tap number is (job+1)/2.
    // ------------------------------------------------------------------
    always_comb begin
        tap_w   = ({1'b0, r_job} + (JW + 1)'(1)) >> 1;
        tap     = tap_w[1:0];
        use_x   = (r_job == '0) || (r_job[0] && (r_job != LAST_JOB));
        case (tap)
            2'd0:    coef = r_coef_b[0];
            2'd1:    coef = use_x ? r_coef_b[1] : r_coef_a[0];
            2'd2:    coef = use_x ? r_coef_b[2] : r_coef_a[1];
            default: coef = r_coef_a[2];
        endcase
        coef_re = coef[CFG_W-1:COEF_W];
        coef_im = coef[COEF_W-1:0];
        // Phases: re*cr, im*ci (subtracted), re*ci, im*cr
        if (r_ph[0]) begin
            op_s = use_x ? r_x_im : r_y_im;
        end else begin
            op_s = use_x ? r_x_re : r_y_re;
        end
        op_c  = (r_ph == 2'd1 || r_ph == 2'd2) ? coef_im : coef_re;
        mul_w = PW'(op_s) * PW'(op_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tg_vld <= 1'b0;
        end else begin
            r_tg_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= mul_w;
        r_tg_job <= r_job;
        r_tg_ph  <= r_ph;
    end

    // ------------------------------------------------------------------
    // Accumulate and apply each finished real or imaginary part
    // ------------------------------------------------------------------
    always_comb begin
        tg_tap_w = ({1'b0, r_tg_job} + (JW + 1)'(1)) >> 1;
        tg_tap   = tg_tap_w[1:0];
        wr_idx   = tg_tap - 2'd1;
        tg_first = (r_tg_job == '0);
        tg_final = (r_tg_job == LAST_JOB);
        tg_bterm = r_tg_job[0] && !tg_final;
        tg_aterm = !r_tg_job[0] && !tg_first;

        prod_ext = AW'(r_prod);
        sum      = (r_tg_ph == 2'd1) ? (r_acc - prod_ext) : (r_acc + prod_ext);
        rnd      = {sum[AW-1], sum} + ROUND_HALF;
        part_v   = rnd[AW:ROUND_SH];
        v_ext    = UW'(part_v);

        dly_rd = '0;
        for (int k = 0; k < ORD; k++) begin
            if (tg_tap == 2'(k)) begin
                dly_rd = r_tg_ph[1] ? r_dly_im[k] : r_dly_re[k];
            end
        end
        base_ext = UW'(dly_rd);
        upd_val  = base_ext + v_ext;

        if (tg_aterm) begin
            wr_pre = (r_tg_ph[1] ? r_upd_im : r_upd_re) - v_ext;
        end else begin
            wr_pre = -v_ext;
        end
        wr_val = sat_state(wr_pre);
        wr_re  = r_tg_vld && (r_tg_ph == 2'd1) && (tg_aterm || tg_final);
        wr_im  = r_tg_vld && (r_tg_ph == 2'd3) && (tg_aterm || tg_final);

        y_re_c = round_out(r_upd_re);
        y_im_c = round_out(r_upd_im);
    end

    always_ff @(posedge i_clk) begin
        if (r_tg_vld) begin
            if (!r_tg_ph[0]) begin
                r_acc <= prod_ext;
            end else if (tg_first || tg_bterm) begin
                if (r_tg_ph[1]) begin
                    r_upd_im <= upd_val;
                end else begin
                    r_upd_re <= upd_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ORD; k++) begin
                r_dly_re[k] <= '0;
                r_dly_im[k] <= '0;
            end
        end else begin
            for (int k = 0; k < ORD; k++) begin
                if (wr_re && wr_idx == 2'(k)) begin
                    r_dly_re[k] <= wr_val;
                end
                if (wr_im && wr_idx == 2'(k)) begin
                    r_dly_im[k] <= wr_val;
                end
            end
        end
    end

    // Sample capture and rounded output, which also feeds the feedback terms
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_x_re <= i_sample_re;
            r_x_im <= i_sample_im;
        end
        if (y_load) begin
            r_y_re <= y_re_c[SAMPLE_W-1:0];
            r_y_im <= y_im_c[SAMPLE_W-1:0];
            r_clip <= y_re_c[SAMPLE_W] | y_im_c[SAMPLE_W];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_re   <= r_y_re;
            r_out_im   <= r_y_im;
            r_out_clip <= r_clip;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_out_re  = r_out_re;
    assign o_out_im  = r_out_im;
    assign o_clipped = r_out_clip;

endmodule

### rtl/core/cif_checker.sv
// ----------------------------------------------------------------------------
// Complex IIR filter port checker
// Watches the top-level ports of the filter and flags sequencing slips.
// ----------------------------------------------------------------------------
module cif_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [cif_pkg::SAMPLE_W-1:0] o_out_re,
    input logic signed [cif_pkg::SAMPLE_W-1:0] o_out_im,
    input logic                                o_clipped
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_re) && $stable(o_out_im)
                               && $stable(o_clipped))
        else $error("stalled result changed");

    // Once a request is taken the filter is busy on the next cycle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("filter not busy after accepting a request");

    // A new result only appears at the end of a request in work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while filter was idle");

    // A clipped result carries a full-scale value in at least one part.
    a_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> (o_out_re == 16'h7fff || o_out_re == 16'h8000 ||
                                  o_out_im == 16'h7fff || o_out_im == 16'h8000))
        else $error("clip flag set without a saturated part");

endmodule

bind complex_iir_filter cif_checker u_cif_checker (.*);

### tb/cif_filter_checker.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// Complex IIR filter checker
// Watches the sample and result channels and the coefficient port. It keeps
// its own fixed-point copy of the filter state, predicts each output on
// request acceptance and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module cif_filter_checker #(
    parameter int ORDER = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_smp_valid,
    input  logic                                  i_smp_stall,
    input  logic signed [cif_pkg::SAMPLE_W-1:0]   i_smp_re,
    input  logic signed [cif_pkg::SAMPLE_W-1:0]   i_smp_im,
    input  logic                                  i_res_valid,
    input  logic                                  i_res_stall,
    input  logic signed [cif_pkg::SAMPLE_W-1:0]   i_res_re,
    input  logic signed [cif_pkg::SAMPLE_W-1:0]   i_res_im,
    input  logic                                  i_res_clipped,
    input  logic                                  i_cfg_we,
    input  cif_pkg::t_cfg_idx                     i_cfg_idx,
    input  logic [cif_pkg::CFG_W-1:0]             i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked,
    output int                                    o_clipped
);
    import cif_pkg::*;

    localparam int     EFF_ORDER = (ORDER < 1) ? 1 : ((ORDER > 3) ? 3 : ORDER);
    localparam longint PROD_HALF = longint'(1) <<< (ROUND_SH - 1);
    localparam longint OUT_HALF  = longint'(1) <<< (OUT_SH - 1);
    localparam longint STATE_MAX = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint STATE_MIN = -(longint'(1) <<< (STATE_W - 1));
    localparam longint OUT_MAX   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN   = -(longint'(1) <<< (SAMPLE_W - 1));

    typedef struct {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       clip;
    } t_filt_result;

    logic [CFG_W-1:0] num_coef [3];
    logic [CFG_W-1:0] den_coef [4];     // entry 0 is the normalised a0 and never used
    longint           line_re  [3];
    longint           line_im  [3];
    t_filt_result     expected_out [$];
    t_filt_result     want;

    // Complex sample times packed Q4.28 coefficient, each part rounded to Q16.24.
    function automatic void cplx_mul_round(input longint xr, input longint xi,
                                           input logic [CFG_W-1:0] c,
                                           output longint p_re, output longint p_im);
        longint cr;
        longint ci;
        cr = longint'($signed(c[2*COEF_W-1:COEF_W]));
        ci = longint'($signed(c[COEF_W-1:0]));
        p_re = (xr * cr - xi * ci + PROD_HALF) >>> ROUND_SH;
        p_im = (xr * ci + xi * cr + PROD_HALF) >>> ROUND_SH;
    endfunction

    function automatic longint round_out(input longint v, inout logic clip);
        longint r;
        r = (v + OUT_HALF) >>> OUT_SH;
        if (r > OUT_MAX) begin
            clip = 1'b1;
            r = OUT_MAX;
        end else if (r < OUT_MIN) begin
            clip = 1'b1;
            r = OUT_MIN;
        end
        return r;
    endfunction

    function automatic longint sat_state(input longint v);
        if (v > STATE_MAX)
            return STATE_MAX;
        if (v < STATE_MIN)
            return STATE_MIN;
        return v;
    endfunction

    // One sample through the transposed structure; the delay line is updated in place.
    // Feedback uses the rounded and saturated output, exactly as it leaves the block.
    function automatic t_filt_result filter_step(input logic signed [SAMPLE_W-1:0] s_re,
                                                 input logic signed [SAMPLE_W-1:0] s_im);
        t_filt_result res;
        longint       xr, xi, p_re, p_im, q_re, q_im, yr, yi;
        logic         clip;
        int           n;
        xr = s_re;
        xi = s_im;
        clip = 1'b0;
        cplx_mul_round(xr, xi, num_coef[0], p_re, p_im);
        yr = round_out(p_re + line_re[0], clip);
        yi = round_out(p_im + line_im[0], clip);
        for (n = 0; n < EFF_ORDER - 1; n++) begin
            cplx_mul_round(xr, xi, num_coef[n+1], p_re, p_im);
            cplx_mul_round(yr, yi, den_coef[n+1], q_re, q_im);
            line_re[n] = sat_state(line_re[n+1] + p_re - q_re);
            line_im[n] = sat_state(line_im[n+1] + p_im - q_im);
        end
        cplx_mul_round(yr, yi, den_coef[EFF_ORDER], q_re, q_im);
        line_re[EFF_ORDER-1] = sat_state(-q_re);
        line_im[EFF_ORDER-1] = sat_state(-q_im);
        res.re   = yr[SAMPLE_W-1:0];
        res.im   = yi[SAMPLE_W-1:0];
        res.clip = clip;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                num_coef[k] = '0;
                line_re[k]  = 0;
                line_im[k]  = 0;
            end
            for (int k = 0; k < 4; k++)
                den_coef[k] = '0;
            num_coef[0] = {ONE_Q4_28, {COEF_W{1'b0}}};
            expected_out.delete();
        end else begin
            // Results are retired before a new request is predicted on the same edge.
            if (i_res_valid && !i_res_stall) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected result re=%0d im=%0d clipped=%0b",
                             $time, i_res_re, i_res_im, i_res_clipped);
                    o_fail_count++;
                end else begin
                    want = expected_out.pop_front();
                    o_checked++;
                    if (want.clip)
                        o_clipped++;
                    if (i_res_re !== want.re) begin
                        $display("%0t: out_re mismatch, expected %0d, actual %0d",
                                 $time, want.re, i_res_re);
                        o_fail_count++;
                    end
                    if (i_res_im !== want.im) begin
                        $display("%0t: out_im mismatch, expected %0d, actual %0d",
                                 $time, want.im, i_res_im);
                        o_fail_count++;
                    end
                    if (i_res_clipped !== want.clip) begin
                        $display("%0t: clipped mismatch, expected %0b, actual %0b",
                                 $time, want.clip, i_res_clipped);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_B0: num_coef[0] = i_cfg_data;
                    CFG_B1: num_coef[1] = i_cfg_data;
                    CFG_B2: num_coef[2] = i_cfg_data;
                    CFG_A1: den_coef[1] = i_cfg_data;
                    CFG_A2: den_coef[2] = i_cfg_data;
                    CFG_A3: den_coef[3] = i_cfg_data;
                    default: ;  // indexes above the last tap are dropped
                endcase
            end
            if (i_smp_valid && !i_smp_stall)
                expected_out.push_back(filter_step(i_smp_re, i_smp_im));
        end
        o_pending = expected_out.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// Complex IIR filter testbench
// Drives samples and coefficient sets into the filter under several pacing
// modes, including a long output hold-off, and lets the checker judge every
// result. Prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
module testbench;
    import cif_pkg::*;

    localparam int ORDER           = 2;
    localparam int LATENCY         = 8 * ORDER + 4;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int HOLD_CYCLES     = 300;
    localparam int BUSY_PCT        = 82;
    localparam int MIXED_PCT       = 24;

    // Indexes past the last tap; writes to them must leave the filter untouched.
    localparam t_cfg_idx CFG_BEYOND_A = 3'd6;
    localparam t_cfg_idx CFG_BEYOND_B = 3'd7;

    localparam logic [COEF_W-1:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] Q_MIN   = 32'h8000_0000;
    localparam logic [COEF_W-1:0] Q_ZERO  = 32'h0000_0000;

    typedef enum int {SET_TUNED, SET_WILD, SET_GENTLE, SET_CORNER} t_coef_set;
    typedef enum int {PACE_FREE, PACE_SLOW_SRC, PACE_SLOW_SINK, PACE_BOTH} t_pace;

    logic                       clk;
    logic                       rst_n;
    logic                       smp_valid;
    logic                       smp_stall;
    logic signed [SAMPLE_W-1:0] smp_re;
    logic signed [SAMPLE_W-1:0] smp_im;
    logic                       res_valid;
    logic                       res_stall;
    logic signed [SAMPLE_W-1:0] res_re;
    logic signed [SAMPLE_W-1:0] res_im;
    logic                       res_clipped;
    logic                       cfg_we;
    t_cfg_idx                   cfg_idx;
    logic [CFG_W-1:0]           cfg_data;

    int fail_count;
    int pending;
    int checked;
    int clipped;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int sets_used      = 0;

    complex_iir_filter #(
        .ORDER (ORDER)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (smp_valid),
        .o_stall     (smp_stall),
        .i_sample_re (smp_re),
        .i_sample_im (smp_im),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_out_re    (res_re),
        .o_out_im    (res_im),
        .o_clipped   (res_clipped),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    cif_filter_checker #(
        .ORDER (ORDER)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_smp_valid   (smp_valid),
        .i_smp_stall   (smp_stall),
        .i_smp_re      (smp_re),
        .i_smp_im      (smp_im),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_res_re      (res_re),
        .i_res_im      (res_im),
        .i_res_clipped (res_clipped),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_clipped     (clipped)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Run timed out with %0d results still outstanding.", pending);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, or one long hold-off so that the filter backs up.
    initial begin
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so back-to-back requests need no extra cycle.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
                               input logic signed [SAMPLE_W-1:0] im);
        while ($urandom_range(99) < send_idle_pct) begin
            smp_valid <= 1'b0;
            @(negedge clk);
        end
        smp_valid <= 1'b1;
        smp_re    <= re;
        smp_im    <= im;
        @(posedge clk);
        while (smp_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic finish_burst();
        smp_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_coef(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_coefs(input logic [CFG_W-1:0] b0, input logic [CFG_W-1:0] b1,
                              input logic [CFG_W-1:0] b2, input logic [CFG_W-1:0] a1,
                              input logic [CFG_W-1:0] a2, input logic [CFG_W-1:0] a3);
        write_coef(CFG_B0, b0);
        write_coef(CFG_B1, b1);
        write_coef(CFG_B2, b2);
        write_coef(CFG_A1, a1);
        write_coef(CFG_A2, a2);
        write_coef(CFG_A3, a3);
        sets_used++;
    endtask

    function automatic logic [CFG_W-1:0] pick_coef(input t_coef_set mode);
        logic [CFG_W-1:0] c;
        int               k;
        for (k = 0; k < 2; k++) begin
            case (mode)
                SET_WILD:   c[COEF_W*k +: COEF_W] = $urandom;
                // Magnitudes up to one, so the loop mostly stays out of saturation.
                SET_GENTLE: c[COEF_W*k +: COEF_W] = $urandom_range(32'h2000_0000)
                                                    - 32'h1000_0000;
                default: begin
                    case ($urandom_range(3))
                        0:       c[COEF_W*k +: COEF_W] = Q_MAX;
                        1:       c[COEF_W*k +: COEF_W] = Q_MIN;
                        2:       c[COEF_W*k +: COEF_W] = ONE_Q4_28;
                        default: c[COEF_W*k +: COEF_W] = Q_ZERO;
                    endcase
                end
            endcase
        end
        return c;
    endfunction

    task automatic apply_coef_set(input t_coef_set mode);
        if (mode == SET_TUNED) begin
            // b0 = 0.5, b1 = 0.25+0.25j, b2 = 0.25, a1 = -0.75+0.25j,
            // a2 = 0.375-0.125j, a3 = 0.125
            load_coefs({32'h0800_0000, Q_ZERO}, {32'h0400_0000, 32'h0400_0000},
                       {32'h0400_0000, Q_ZERO}, {32'hF400_0000, 32'h0400_0000},
                       {32'h0600_0000, 32'hFE00_0000}, {32'h0200_0000, Q_ZERO});
        end else begin
            load_coefs(pick_coef(mode), pick_coef(mode), pick_coef(mode),
                       pick_coef(mode), pick_coef(mode), pick_coef(mode));
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            1, 2:    return SAMPLE_W'($urandom_range(600) - 300);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        t_pace     pace;
        t_coef_set set_sel;
        int        p;
        rst_n     = 1'b0;
        smp_valid = 1'b0;
        smp_re    = '0;
        smp_im    = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_B0;
        cfg_data  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset coefficients give a unity pass-through; the sample extremes come out unchanged.
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'shFFFF, 16'sh0001);
        send_sample(16'sh0001, 16'shFFFF);
        finish_burst();

        write_coef(CFG_BEYOND_A, {CFG_W{1'b1}});
        write_coef(CFG_BEYOND_B, {Q_MIN, Q_MAX});
        send_sample(16'sh1234, 16'shEDCB);
        send_sample(16'sh8000, 16'sh7FFF);
        finish_burst();

        // Full-scale taps: the output saturates and the clipped value feeds back.
        load_coefs({Q_MAX, Q_MAX}, {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX},
                   {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX}, {Q_MAX, Q_MAX});
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0001, 16'sh0000);
        finish_burst();

        load_coefs({Q_MIN, Q_MIN}, {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN},
                   {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN}, {Q_MIN, Q_MIN});
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000);
        finish_burst();

        for (p = 0; p < 8; p++) begin
            set_sel = t_coef_set'((p + p / 4) % 4);
            pace    = t_pace'(p % 4);
            apply_coef_set(set_sel);
            case (pace)
                PACE_FREE: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                PACE_SLOW_SRC: begin
                    send_idle_pct  = BUSY_PCT;
                    recv_stall_pct = 0;
                end
                PACE_SLOW_SINK: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = BUSY_PCT;
                end
                default: begin
                    send_idle_pct  = MIXED_PCT;
                    recv_stall_pct = MIXED_PCT;
                end
            endcase
            if (p == 4)
                hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE)
                send_sample(pick_sample(), pick_sample());
            finish_burst();
        end

        repeat (2 * LATENCY) @(negedge clk);
        $display("Checked %0d filter outputs, %0d of them saturated, over %0d tap sets",
                 checked, clipped, sets_used);
        $display("with free, slow-source, slow-sink and mixed pacing and one long hold-off.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
